// ===== hdl/ple_pkg.sv =====
// shared types and constants for the positional list engine
// no dependencies; imported by ple_ram users and the top level
`default_nettype none

package ple_pkg;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_POS   = 3'd5
    } ple_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } ple_status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_INS  = 2'd1,
        ST_DEL  = 2'd2,
        ST_DONE = 2'd3
    } ple_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } ple_in_t;

    typedef struct packed {
        ple_status_t               status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        count;
    } ple_out_t;

endpackage

`default_nettype wire

// ===== hdl/ple_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ple_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/positional_list_engine.sv =====
// top level of the positional list engine: control fsm around one element ram
// depends on ple_pkg and ple_ram
`default_nettype none

// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | in_data  (ple_in_t: action, value, position)
// output   | out_valid | out_stall | out_data (ple_out_t: status, removed_value, count)
//
// one item at a time; elements live in one ram with a registered read.
// an insert at slot k moves the elements from slot k to the tail back one slot, tail
// first, then writes the new value at slot k; a delete reads slot k and shifts the later
// elements forward, one element a cycle; a rejected or unknown action goes to the result.
// reset clears the count and control only; ram contents are don't-care until written.
// a waiting result sits in the output register while the next item is taken.

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire ple_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_stall,
    output ple_out_t     out_data
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    ple_state_t           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [VALUE_W-1:0]   removed_reg, removed_next;
    ple_status_t          status_reg, status_next;
    logic                 lat_wr_reg, lat_wr_next;
    logic                 lat_cap_reg, lat_cap_next;
    logic [CW-1:0]        lat_waddr_reg, lat_waddr_next;
    logic                 out_valid_reg, out_valid_next;
    ple_out_t             out_data_reg, out_data_next;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [VALUE_W-1:0]   rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VALUE_W-1:0]   wr_data;

    logic [POS_W-1:0]     pos_adj;
    logic [CMPW-1:0]      pos_ext;
    logic [CMPW-1:0]      count_ext;
    logic [CW-1:0]        pos_idx;
    logic [CW-1:0]        ptr_m1;
    logic                 is_full;
    logic                 is_empty;

    ple_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // position zero acts as one
    assign pos_adj   = (in_data.position == '0) ? POS_W'(1) : in_data.position;
    assign pos_ext   = CMPW'(pos_adj);
    assign count_ext = CMPW'(count_reg);
    assign pos_idx   = CW'(pos_adj - POS_W'(1));
    assign ptr_m1    = ptr_reg - CW'(1);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        lat_wr_next    = 1'b0;
        lat_cap_next   = 1'b0;
        lat_waddr_next = lat_waddr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = lat_waddr_reg[AW-1:0];
        wr_data        = rd_data;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // element moved one slot: read last cycle, written now
        if (lat_wr_reg)
        begin
            wr_en = 1'b1;
        end
        if (lat_cap_reg)
        begin
            removed_next = rd_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    status_next  = STAT_OK;
                    removed_next = '0;
                    val_next     = in_data.value;
                    ptr_next     = count_reg;
                    state_next   = ST_DONE;
                    case (ple_action_t'(in_data.action))
                        ACT_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_INS;
                            end
                        end
                        ACT_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = ST_INS;
                            end
                        end
                        ACT_INS_POS:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (pos_ext > count_ext + CMPW'(1))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                idx_next   = pos_idx;
                                state_next = ST_INS;
                            end
                        end
                        ACT_DEL_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                ptr_next   = '0;
                                state_next = ST_DEL;
                            end
                        end
                        ACT_DEL_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = count_reg - CW'(1);
                                ptr_next   = count_reg - CW'(1);
                                state_next = ST_DEL;
                            end
                        end
                        ACT_DEL_POS:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (pos_ext > count_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                idx_next   = pos_idx;
                                ptr_next   = pos_idx;
                                state_next = ST_DEL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_INS:
            begin
                // walk down from the tail, moving each element back one slot
                if (ptr_reg != idx_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ptr_m1[AW-1:0];
                    lat_wr_next    = 1'b1;
                    lat_waddr_next = ptr_reg;
                    ptr_next       = ptr_m1;
                end
                else if (!lat_wr_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[AW-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DEL:
            begin
                // first read fetches the removed element, later ones shift forward
                if (ptr_reg != count_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg[AW-1:0];
                    if (ptr_reg == idx_reg)
                    begin
                        lat_cap_next = 1'b1;
                    end
                    else
                    begin
                        lat_wr_next    = 1'b1;
                        lat_waddr_next = ptr_m1;
                    end
                    ptr_next = ptr_reg + CW'(1);
                end
                else if (!lat_wr_reg && !lat_cap_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.removed_value = removed_reg;
                    out_data_next.count         = COUNT_W'(count_reg);
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lat_wr_reg    <= 1'b0;
            lat_cap_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lat_wr_reg    <= lat_wr_next;
            lat_cap_reg   <= lat_cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        lat_waddr_reg <= lat_waddr_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire
